// ----- rtl/core/rmc_pkg.sv -----
// Shared types, constants and prefix table for the RMC sentence capture block.
package rmc_pkg;

    localparam int BUF_DEPTH_DEFAULT = 128;
    localparam int PREFIX_LEN        = 6;
    localparam int RES_FIFO_DEPTH    = 4;

    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] DOLLAR    = 8'h24;

    typedef struct packed {
        logic [7:0] rx_char;
        logic       pps_present;
    } rmc_in_t;

    typedef struct packed {
        logic       write_valid;
        logic [6:0] write_addr;
        logic [7:0] write_data;
        logic       sentence_done;
        logic       time_update_request;
        logic       overflow;
        logic       last;
    } rmc_out_t;

    // Results of one character: how many, then up to two result beats.
    typedef struct packed {
        logic [1:0] count;
        rmc_out_t   first;
        rmc_out_t   second;
    } rmc_pair_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = DOLLAR;
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h52;  // R
            3'd4:    ch = 8'h4D;  // M
            3'd5:    ch = 8'h43;  // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/rmc_parser.sv -----
// Prefix hunt and sentence fill state, producing up to two results per character.
module rmc_parser #(
    parameter int BUF_DEPTH = rmc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               consume,
    input  rmc_pkg::rmc_in_t   in_data,
    input  logic               gps_enable,
    output rmc_pkg::rmc_pair_t pair
);

    localparam int FW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_WAIT_DOLLAR = 2'd0,
        PH_PREFIX      = 2'd1,
        PH_BODY        = 2'd2
    } phase_t;

    phase_t          phase_reg,  phase_next;
    logic [2:0]      prefix_reg, prefix_next;
    logic [FW-1:0]   fill_reg,   fill_next;
    logic [FW-1:0]   fill_adv;
    logic [7:0]      ch;
    rmc_pkg::rmc_pair_t pair_c;

    function automatic logic [FW-1:0] advance(input logic [FW-1:0] f);
        return (f < FW'(BUF_DEPTH)) ? f + FW'(1) : f;
    endfunction

    function automatic rmc_pkg::rmc_out_t make_write(
        input logic [FW-1:0] f,
        input logic [7:0]    data,
        input logic          done,
        input logic          req,
        input logic          lst
    );
        rmc_pkg::rmc_out_t r;
        r = '0;
        if (f < FW'(BUF_DEPTH)) begin
            r.write_valid = 1'b1;
            r.write_addr  = 7'(f);
            r.write_data  = data;
        end else begin
            r.overflow = 1'b1;
        end
        r.sentence_done       = done;
        r.time_update_request = req;
        r.last                = lst;
        return r;
    endfunction

    assign ch       = in_data.rx_char;
    assign fill_adv = advance(fill_reg);

    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        fill_next   = fill_reg;
        pair_c      = '0;
        case (phase_reg)
            PH_PREFIX: begin
                if (prefix_reg < 3'(rmc_pkg::PREFIX_LEN)
                    && ch == rmc_pkg::prefix_char(prefix_reg)) begin
                    pair_c.count = 2'd1;
                    pair_c.first = make_write(fill_reg, ch, 1'b0, 1'b0, 1'b1);
                    prefix_next  = prefix_reg + 3'd1;
                    fill_next    = fill_adv;
                    if (prefix_next == 3'(rmc_pkg::PREFIX_LEN)) begin
                        phase_next = PH_BODY;
                    end
                end else begin
                    // drop the partial prefix and wait for a fresh '$'
                    phase_next  = PH_WAIT_DOLLAR;
                    prefix_next = '0;
                    fill_next   = '0;
                end
            end
            PH_BODY: begin
                if (ch != rmc_pkg::LINE_FEED) begin
                    pair_c.count = 2'd1;
                    pair_c.first = make_write(fill_reg, ch, 1'b0, 1'b0, 1'b1);
                    fill_next    = fill_adv;
                end else begin
                    // store the newline, then the terminator one place further
                    pair_c.count  = 2'd2;
                    pair_c.first  = make_write(fill_reg, ch, 1'b0, 1'b0, 1'b0);
                    pair_c.second = make_write(fill_adv, 8'h00, 1'b1,
                                               gps_enable & in_data.pps_present, 1'b1);
                    phase_next    = PH_WAIT_DOLLAR;
                    prefix_next   = '0;
                    fill_next     = '0;
                end
            end
            default: begin
                if (ch == rmc_pkg::DOLLAR) begin
                    pair_c.count = 2'd1;
                    pair_c.first = make_write(fill_reg, ch, 1'b0, 1'b0, 1'b1);
                    phase_next   = PH_PREFIX;
                    prefix_next  = 3'd1;
                    fill_next    = fill_adv;
                end else begin
                    phase_next = PH_WAIT_DOLLAR;
                end
            end
        endcase
    end

    always_comb begin
        pair = pair_c;
        if (!consume) begin
            pair.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            prefix_reg <= '0;
            fill_reg   <= '0;
        end else if (consume) begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/rmc_result_fifo.sv -----
// Small result queue taking up to two result beats per cycle and giving one.
module rmc_result_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  rmc_pkg::rmc_pair_t pair,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output rmc_pkg::rmc_out_t  m_data
);

    localparam int D  = rmc_pkg::RES_FIFO_DEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    rmc_pkg::rmc_out_t mem [D];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;

    assign room    = (count_reg <= CW'(D - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid & m_ready;

    assign wr_ptr_next = wr_ptr_reg + PW'(pair.count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(pair.count) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (pair.count != 2'd0) begin
            mem[wr_ptr_reg] <= pair.first;
        end
        if (pair.count == 2'd2) begin
            mem[wr_ptr_reg + PW'(1)] <= pair.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/nmea_rmc_sentence_capture_unit.sv -----
// Top level of the RMC sentence capture: input register, parser, result queue.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  rmc_in_t  (rx_char, pps_present)
//   m_        out        m_valid / m_ready  rmc_out_t (buffer write, done, flags)
//   cfg_      in         cfg_wr_en          gps_enable bit
//
// While the queue has room, one character per cycle enters the input register
// and is parsed from there; its results are written to the result queue.
// A newline gives two result beats, so with m_ready held high the block takes
// one character per cycle while the queue has room, and gives an extra beat per newline.
// s_ready stays high while the queue has room for two beats; m_ready low stalls
// the queue, then the input register. Reset clears the parse state and queue.
module nmea_rmc_sentence_capture_unit #(
    parameter int BUF_DEPTH = rmc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmc_pkg::rmc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rmc_pkg::rmc_out_t m_data
);

    logic               gps_enable_reg;
    logic               in_valid_reg, in_valid_next;
    rmc_pkg::rmc_in_t   in_data_reg;
    logic               room;
    logic               consume;
    logic               s_accept;
    rmc_pkg::rmc_pair_t pair;

    assign consume       = in_valid_reg & room;
    assign s_ready       = ~in_valid_reg | consume;
    assign s_accept      = s_valid & s_ready;
    assign in_valid_next = s_accept | (in_valid_reg & ~consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gps_enable_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                gps_enable_reg <= cfg_wr_data;
            end
        end
    end

    // hold the beat until the parser takes it
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
    end

    rmc_parser #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .consume    (consume),
        .in_data    (in_data_reg),
        .gps_enable (gps_enable_reg),
        .pair       (pair)
    );

    rmc_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pair    (pair),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sentence_done |-> m_data.last)
        else $error("sentence_done beat without last");

    a_write_not_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_valid |-> !m_data.overflow)
        else $error("beat both writes and overflows");

    a_request_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.time_update_request |-> m_data.sentence_done)
        else $error("time update request outside a completed sentence");

    a_pair_only_on_consume: assert property (@(posedge aclk) disable iff (!aresetn)
        pair.count != 2'd0 |-> consume && room)
        else $error("results pushed without a consumed beat");

endmodule

// ----- tb/tb.sv -----
// Testbench for nmea_rmc_sentence_capture_unit: queued character stream, scoreboard check.
`timescale 1ns / 100ps

module tb;

    import rmc_pkg::*;

    localparam int BUF_DEPTH   = BUF_DEPTH_DEFAULT;
    localparam int HALF_PERIOD = 10;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 300;
    localparam logic [47:0] RMC_HEAD = "$GPRMC";

    typedef enum logic [1:0] {
        HUNT_DOLLAR,
        MATCH_PREFIX,
        IN_BODY
    } parse_state_t;

    logic     aclk        = 1'b0;
    logic     aresetn     = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    rmc_in_t  s_data      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    rmc_out_t m_data;

    // Stimulus and expected beats
    rmc_in_t  char_queue[$];
    rmc_out_t write_queue[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    bit pressure_go    = 1'b0;
    bit hold_off       = 1'b0;

    // Parser state as predicted from accepted characters
    parse_state_t parse_state = MATCH_PREFIX;
    int           prefix_pos  = 0;
    int           fill_pos    = 0;
    logic         gps_en      = 1'b0;

    nmea_rmc_sentence_capture_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic logic [7:0] head_char(int pos);
        return RMC_HEAD[47 - 8 * pos -: 8];
    endfunction

    function automatic void push_write(logic [7:0] data, logic done, logic req, logic last_beat);
        rmc_out_t b;
        b = '0;
        if (fill_pos < BUF_DEPTH) begin
            b.write_valid = 1'b1;
            b.write_addr  = fill_pos[6:0];
            b.write_data  = data;
            fill_pos++;
        end else begin
            b.overflow = 1'b1;
        end
        b.sentence_done       = done;
        b.time_update_request = req;
        b.last                = last_beat;
        write_queue.push_back(b);
    endfunction

    function automatic void predict_writes(rmc_in_t it);
        case (parse_state)
            MATCH_PREFIX: begin
                if (prefix_pos < PREFIX_LEN && it.rx_char == head_char(prefix_pos)) begin
                    prefix_pos++;
                    push_write(it.rx_char, 1'b0, 1'b0, 1'b1);
                    if (prefix_pos >= PREFIX_LEN)
                        parse_state = IN_BODY;
                end else begin
                    // drop the partial prefix and the offending character
                    parse_state = HUNT_DOLLAR;
                    prefix_pos  = 0;
                    fill_pos    = 0;
                end
            end
            IN_BODY: begin
                if (it.rx_char != LINE_FEED) begin
                    push_write(it.rx_char, 1'b0, 1'b0, 1'b1);
                end else begin
                    push_write(it.rx_char, 1'b0, 1'b0, 1'b0);
                    push_write(8'h00, 1'b1, gps_en & it.pps_present, 1'b1);
                    parse_state = HUNT_DOLLAR;
                    prefix_pos  = 0;
                    fill_pos    = 0;
                end
            end
            default: begin
                if (it.rx_char == DOLLAR) begin
                    parse_state = MATCH_PREFIX;
                    prefix_pos  = 1;
                    push_write(it.rx_char, 1'b0, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic string beat_str(rmc_out_t b);
        return $sformatf("wv=%0b addr=%0d data=%02h done=%0b req=%0b ovf=%0b last=%0b",
                         b.write_valid, b.write_addr, b.write_data, b.sentence_done,
                         b.time_update_request, b.overflow, b.last);
    endfunction

    // Sender: hold the beat until accepted, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                predict_writes(s_data);
            if (!s_valid || s_ready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= char_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted beat against the oldest prediction
    always @(posedge aclk) begin : result_monitor
        rmc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (write_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected beat: %s", $realtime, beat_str(m_data));
                end else begin
                    want = write_queue.pop_front();
                    if (m_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("    expected %s", beat_str(want));
                            $display("    actual   %s", beat_str(m_data));
                        end
                    end
                end
            end
            m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the result queue fills and input backs up
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic push_char(logic [7:0] c, logic pps);
        rmc_in_t it;
        it.rx_char     = c;
        it.pps_present = pps;
        char_queue.push_back(it);
    endtask

    task automatic queue_prefix(int n);
        for (int i = 0; i < n; i++)
            push_char(head_char(i), 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_sentence(int body_len, logic pps);
        logic [7:0] c;
        queue_prefix(PREFIX_LEN);
        for (int i = 0; i < body_len; i++) begin
            do c = 8'($urandom_range(0, 255)); while (c == LINE_FEED);
            push_char(c, 1'($urandom_range(0, 1)));
        end
        push_char(LINE_FEED, pps);
    endtask

    task automatic queue_random(int n);
        int         target;
        int         pick;
        int         k;
        logic [7:0] c;
        target = char_queue.size() + n;
        while (char_queue.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 99) < 5)
                    queue_sentence($urandom_range(115, 140), 1'($urandom_range(0, 1)));
                else
                    queue_sentence($urandom_range(0, 30), 1'($urandom_range(0, 1)));
            end else if (pick < 82) begin
                // break the prefix partway, sometimes with a fresh '$'
                k = $urandom_range(1, PREFIX_LEN - 1);
                queue_prefix(k);
                if ($urandom_range(0, 2) == 0) begin
                    c = DOLLAR;
                end else begin
                    do c = 8'($urandom_range(0, 255)); while (c == head_char(k));
                end
                push_char(c, 1'($urandom_range(0, 1)));
            end else if (pick < 94) begin
                push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                push_char(($urandom_range(0, 1) != 0) ? LINE_FEED : DOLLAR,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (char_queue.size() != 0 || s_valid || write_queue.size() != 0)
            @(posedge aclk);
        // characters that give no beat may still be in flight
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gps_enable(logic value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gps_en = value;
    endtask

    task automatic run_phase(int send_pct, int recv_pct, logic enable, int n);
        write_gps_enable(enable);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: mismatch straight out of reset, full sentence with extreme bytes,
        // a '$' breaking the prefix, a stray byte while hunting, an empty body
        push_char(8'h80, 1'b1);
        queue_prefix(PREFIX_LEN);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b1);
        push_char(LINE_FEED, 1'b1);
        queue_prefix(3);
        push_char(DOLLAR, 1'b0);
        push_char(8'h58, 1'b1);
        queue_sentence(0, 1'b0);
        wait_drained();

        // Buffer end: terminator dropped, then body bytes dropped, then a terminator that just fits
        write_gps_enable(1'b1);
        queue_sentence(BUF_DEPTH - PREFIX_LEN - 1, 1'b1);
        queue_sentence(BUF_DEPTH + 2, 1'b1);
        queue_sentence(BUF_DEPTH - PREFIX_LEN - 2, 1'b0);
        wait_drained();

        run_phase(0, 0, 1'b1, 130);
        run_phase(69, 0, 1'b0, 130);
        run_phase(0, 69, 1'b1, 130);
        run_phase(28, 28, 1'b0, 130);

        write_gps_enable(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b1;
        for (int i = 0; i < 6; i++)
            queue_sentence($urandom_range(2, 12), 1'($urandom_range(0, 1)));
        wait_drained();

        if (mismatches == 0 && write_queue.size() == 0)
            $display("** nmea_rmc_sentence_capture_unit: PASSED **");
        else
            $display("** nmea_rmc_sentence_capture_unit: FAILED **");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("** nmea_rmc_sentence_capture_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rmc_pkg.sv
rtl/core/rmc_parser.sv
rtl/core/rmc_result_fifo.sv
rtl/core/nmea_rmc_sentence_capture_unit.sv
tb/tb.sv
